@@ hw/rtl/shp_pkg.sv @@
// Shared types, codes and tables for the SPS header parser.
package shp_pkg;

   // number of element codes and idle phase marker
   localparam int unsigned NCODES = 90;
   localparam logic [6:0] PH_IDLE = 7'd127;

   // field kinds: fixed widths are 1..32, Golomb kinds above
   localparam logic [6:0] KUE = 7'd64;
   localparam logic [6:0] KSE = 7'd65;

   // limits
   localparam int unsigned MAX_POC_CYCLE     = 256;
   localparam int unsigned MAX_CPB_COUNT     = 32;
   localparam int unsigned MAX_LEADING_ZEROS = 32;
   localparam int unsigned RSP_FIFO_DEPTH    = 4;

   // presence flag bits
   localparam int unsigned F_LUMA = 0;
   localparam int unsigned F_NAL  = 1;
   localparam int unsigned F_VCL  = 2;

   // error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_GOLOMB = 2'd1;
   localparam logic [1:0] ERR_DEPTH  = 2'd2;
   localparam logic [1:0] ERR_COUNT  = 2'd3;

   // element codes with special handling
   localparam logic [6:0] EC_PROFILE        = 7'd0;
   localparam logic [6:0] EC_SPS_ID         = 7'd7;
   localparam logic [6:0] EC_CHROMA_FORMAT  = 7'd8;
   localparam logic [6:0] EC_SEP_PLANE      = 7'd9;
   localparam logic [6:0] EC_DEPTH_LUMA     = 7'd10;
   localparam logic [6:0] EC_DEPTH_CHROMA   = 7'd11;
   localparam logic [6:0] EC_SCALING_MATRIX = 7'd13;
   localparam logic [6:0] EC_LIST_PRESENT   = 7'd14;
   localparam logic [6:0] EC_SCALE_VALUE    = 7'd15;
   localparam logic [6:0] EC_SCALE_FILL     = 7'd16;
   localparam logic [6:0] EC_LOG2_FRAME_NUM = 7'd17;
   localparam logic [6:0] EC_POC_TYPE       = 7'd18;
   localparam logic [6:0] EC_POC_LSB        = 7'd19;
   localparam logic [6:0] EC_DELTA_ZERO     = 7'd20;
   localparam logic [6:0] EC_POC_CYCLE      = 7'd23;
   localparam logic [6:0] EC_REF_OFFSET     = 7'd24;
   localparam logic [6:0] EC_MAX_REF        = 7'd25;
   localparam logic [6:0] EC_FRAME_MBS      = 7'd29;
   localparam logic [6:0] EC_MB_ADAPTIVE    = 7'd30;
   localparam logic [6:0] EC_DIRECT8X8      = 7'd31;
   localparam logic [6:0] EC_CROP           = 7'd32;
   localparam logic [6:0] EC_CROP_LEFT      = 7'd33;
   localparam logic [6:0] EC_VUI            = 7'd37;
   localparam logic [6:0] EC_ASPECT_PRESENT = 7'd38;
   localparam logic [6:0] EC_ASPECT_IDC     = 7'd39;
   localparam logic [6:0] EC_SAR_WIDTH      = 7'd40;
   localparam logic [6:0] EC_OVERSCAN       = 7'd42;
   localparam logic [6:0] EC_OVERSCAN_APPR  = 7'd43;
   localparam logic [6:0] EC_VIDEO_SIGNAL   = 7'd44;
   localparam logic [6:0] EC_VIDEO_FORMAT   = 7'd45;
   localparam logic [6:0] EC_COLOUR_DESC    = 7'd47;
   localparam logic [6:0] EC_COLOUR_PRIM    = 7'd48;
   localparam logic [6:0] EC_CHROMA_LOC     = 7'd51;
   localparam logic [6:0] EC_LOC_TOP        = 7'd52;
   localparam logic [6:0] EC_TIMING         = 7'd54;
   localparam logic [6:0] EC_UNITS_IN_TICK  = 7'd55;
   localparam logic [6:0] EC_NAL_HRD        = 7'd58;
   localparam logic [6:0] EC_NAL_CPB_CNT    = 7'd59;
   localparam logic [6:0] EC_NAL_BIT_RATE   = 7'd62;
   localparam logic [6:0] EC_NAL_CPB_SIZE   = 7'd63;
   localparam logic [6:0] EC_NAL_CBR        = 7'd64;
   localparam logic [6:0] EC_VCL_HRD        = 7'd69;
   localparam logic [6:0] EC_VCL_CPB_CNT    = 7'd70;
   localparam logic [6:0] EC_VCL_BIT_RATE   = 7'd73;
   localparam logic [6:0] EC_VCL_CPB_SIZE   = 7'd74;
   localparam logic [6:0] EC_VCL_CBR        = 7'd75;
   localparam logic [6:0] EC_LOW_DELAY      = 7'd80;
   localparam logic [6:0] EC_PIC_STRUCT     = 7'd81;
   localparam logic [6:0] EC_RESTRICTION    = 7'd82;
   localparam logic [6:0] EC_MAX_DEC_BUF    = 7'd89;

   // field kind per element code
   localparam logic [6:0] KIND_TAB [NCODES] = '{
      7'd8, 7'd1, 7'd1, 7'd1, 7'd1, 7'd4, 7'd8, KUE, KUE, 7'd1,
      KUE, KUE, 7'd1, 7'd1, 7'd1, KSE, 7'd0, KUE, KUE, KUE,
      7'd1, KSE, KSE, KUE, KSE, KUE, 7'd1, KUE, KUE, 7'd1,
      7'd1, 7'd1, 7'd1, KUE, KUE, KUE, KUE, 7'd1, 7'd1, 7'd8,
      7'd16, 7'd16, 7'd1, 7'd1, 7'd1, 7'd3, 7'd1, 7'd1, 7'd8, 7'd8,
      7'd8, 7'd1, KUE, KUE, 7'd1, 7'd32, 7'd32, 7'd1, 7'd1,
      KUE, 7'd4, 7'd4, KUE, KUE, 7'd1, 7'd5, 7'd5, 7'd5, 7'd5,
      7'd1,
      KUE, 7'd4, 7'd4, KUE, KUE, 7'd1, 7'd5, 7'd5, 7'd5, 7'd5,
      7'd1, 7'd1, 7'd1, 7'd1, KUE, KUE, KUE, KUE, KUE, KUE
   };

   // zigzag scans
   localparam logic [3:0] ZZ4 [16] = '{
      4'd0, 4'd1, 4'd4, 4'd8, 4'd5, 4'd2, 4'd3, 4'd6,
      4'd9, 4'd12, 4'd13, 4'd10, 4'd7, 4'd11, 4'd14, 4'd15
   };

   localparam logic [5:0] ZZ8 [64] = '{
      6'd0, 6'd1, 6'd8, 6'd16, 6'd9, 6'd2, 6'd3, 6'd10,
      6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4, 6'd5,
      6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
      6'd27, 6'd20, 6'd13, 6'd6, 6'd7, 6'd14, 6'd21, 6'd28,
      6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
      6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
      6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
      6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
   };

   // one result beat
   typedef struct packed {
      logic [6:0]  code;
      logic [7:0]  index;
      logic [32:0] value;
      logic        use_default;
      logic        warning;
      logic [1:0]  error;
      logic        final_res;
   } rsp_type;

   // high fidelity profiles
   function automatic logic is_high(input logic [7:0] p);
      is_high = (p == 8'd100) || (p == 8'd110) || (p == 8'd122) ||
                (p == 8'd244) || (p == 8'd44);
   endfunction

endpackage

@@ hw/rtl/h264_sps_header_parser.sv @@
// Top level of the SPS header parser: bit front end and result queue.
//
//  channel | direction | handshake        | beat
//  req     | in        | valid / stall    | start_req, bit_value
//  rsp     | out       | valid / stall    | element_code .. final_res
//  csr     | in        | valid / ready    | max_bit_depth
//
// One payload bit per cycle unless stalled; an element's result enters the
// queue in the cycle its last bit is taken and can leave on the next cycle.
// The queue holds FIFO_DEPTH beats; req_stall rises only while it is full.
// Reset is synchronous; the parser idles until a bit with start_req.
module h264_sps_header_parser
   import shp_pkg::*;
#(
   parameter int unsigned FIFO_DEPTH = RSP_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_start_req,
   input  logic               req_bit_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [6:0]         rsp_element_code,
   output logic [7:0]         rsp_element_index,
   output logic signed [32:0] rsp_value,
   output logic               rsp_use_default,
   output logic               rsp_profile_warning,
   output logic [1:0]         rsp_error_code,
   output logic               rsp_final_res,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [4:0]         csr_max_bit_depth
);

   logic    full, bit_take, push;
   rsp_type push_data, head;

   assign csr_ready = 1'b1;
   assign req_stall = full;
   assign bit_take  = req_valid && !full;

   // front end
   shp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .bit_take      (bit_take),
      .start_req     (req_start_req),
      .bit_value     (req_bit_value),
      .cfg_write     (csr_valid && csr_ready),
      .cfg_max_depth (csr_max_bit_depth),
      .rsp_push      (push),
      .rsp_data      (push_data)
   );

   // back end queue
   shp_queue #(.DEPTH(FIFO_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (rsp_valid && !rsp_stall),
      .full      (full),
      .not_empty (rsp_valid),
      .head      (head)
   );

   assign rsp_element_code    = head.code;
   assign rsp_element_index   = head.index;
   assign rsp_value           = head.value;
   assign rsp_use_default     = head.use_default;
   assign rsp_profile_warning = head.warning;
   assign rsp_error_code      = head.error;
   assign rsp_final_res       = head.final_res;

endmodule

@@ hw/rtl/shp_queue.sv @@
// Result queue between the bit parser and the result channel.
module shp_queue
   import shp_pkg::*;
#(
   parameter int unsigned DEPTH = RSP_FIFO_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    pop,
   output logic    full,
   output logic    not_empty,
   output rsp_type head
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   rsp_type        mem_ff [DEPTH];
   logic [PW-1:0]  wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;

   assign full      = (cnt_ff == CW'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign head      = mem_ff[rd_ff];

   // pointer and count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hw/rtl/shp_parser.sv @@
// Front end: bit accumulator, Golomb decoder and syntax sequencer.
module shp_parser
   import shp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       bit_take,
   input  logic       start_req,
   input  logic       bit_value,
   input  logic       cfg_write,
   input  logic [4:0] cfg_max_depth,
   output logic       rsp_push,
   output rsp_type    rsp_data
);

   logic [6:0]  phase_ff, phase_in;
   logic [5:0]  lz_ff, lz_in;
   logic [32:0] acc_ff, acc_in;
   logic [5:0]  rem_ff, rem_in;
   logic [7:0]  prof_ff, prof_in;
   logic [1:0]  cf_ff, cf_in;
   logic [7:0]  lc_ff, lc_in;
   logic [7:0]  ll_ff, ll_in;
   logic [3:0]  ln_ff, ln_in;
   logic [5:0]  sp_ff, sp_in;
   logic [7:0]  ls_ff, ls_in;
   logic [2:0]  pf_ff, pf_in;
   logic [4:0]  mbd_ff;

   always_comb begin
      logic [6:0]  ph, kind, nxt, nkind, code;
      logic [5:0]  lz, rem, lz_n, rem_n, pos;
      logic [32:0] acc, acc_n, raw, sv, val;
      logic [7:0]  prof, lc, ll, ls, idx, ns;
      logic [1:0]  cf, err;
      logic [3:0]  ln, nl_num;
      logic [2:0]  pf;
      logic        done, dflt, warn, fin, size16;
      logic [6:0]  nl_code, pos_p1;

      ph = phase_ff; lz = lz_ff; acc = acc_ff; rem = rem_ff; prof = prof_ff;
      cf = cf_ff; lc = lc_ff; ll = ll_ff; ln = ln_ff; pos = sp_ff; ls = ls_ff;
      pf = pf_ff;
      acc_n = '0; rem_n = '0; lz_n = '0; raw = '0; done = 1'b0;
      nxt = '0; nkind = '0; code = '0; idx = '0; val = '0; ns = '0;
      dflt = 1'b0; warn = 1'b0; fin = 1'b0; err = ERR_NONE;

      // new set: cleared state at element 0
      if (start_req) begin
         ph = EC_PROFILE; lz = '0; acc = '0; rem = KIND_TAB[EC_PROFILE][5:0];
         prof = '0; cf = 2'd1; lc = '0; ll = '0; ln = '0; pos = '0;
         ls = 8'd8; pf = '0;
      end

      phase_in = phase_ff; lz_in = lz_ff; acc_in = acc_ff; rem_in = rem_ff;
      prof_in = prof_ff; cf_in = cf_ff; lc_in = lc_ff; ll_in = ll_ff;
      ln_in = ln_ff; sp_in = sp_ff; ls_in = ls_ff; pf_in = pf_ff;
      rsp_push = 1'b0;
      rsp_data = '0;

      kind    = (ph < 7'(NCODES)) ? KIND_TAB[ph] : '0;
      sv      = '0;
      size16  = (ln < 4'd6);
      nl_num  = ln + 4'd1;
      nl_code = (nl_num < ((cf == 2'd3) ? 4'd12 : 4'd8)) ?
                EC_LIST_PRESENT : EC_LOG2_FRAME_NUM;
      pos_p1  = {1'b0, pos} + 7'd1;

      if (bit_take && (start_req || (phase_ff < 7'(NCODES)))) begin
         phase_in = ph; lz_in = lz; acc_in = acc; rem_in = rem; prof_in = prof;
         cf_in = cf; lc_in = lc; ll_in = ll; ln_in = ln; sp_in = pos;
         ls_in = ls; pf_in = pf;

         // bit collection
         acc_n = {acc[31:0], bit_value};
         rem_n = (rem != '0) ? rem - 6'd1 : '0;
         if (kind < KUE) begin
            acc_in = acc_n;
            rem_in = rem_n;
            if (rem_n == '0) begin
               done = 1'b1;
               raw  = acc_n;
            end
         end else if (acc == '0) begin
            if (!bit_value) begin
               lz_n  = lz + 6'd1;
               lz_in = lz_n;
               if (lz_n >= 6'(MAX_LEADING_ZEROS)) begin
                  rsp_push           = 1'b1;
                  rsp_data.code      = ph;
                  rsp_data.error     = ERR_GOLOMB;
                  rsp_data.final_res = 1'b1;
                  phase_in           = PH_IDLE;
               end
            end else if (lz == '0) begin
               done = 1'b1;
            end else begin
               acc_in = 33'd1;
               rem_in = lz;
            end
         end else begin
            acc_in = acc_n;
            rem_in = rem_n;
            if (rem_n == '0) begin
               done = 1'b1;
               raw  = acc_n - 33'd1;
            end
         end

         // element finished
         if (done) begin
            code = ph;
            nxt  = ph + 7'd1;
            sv   = raw[0] ? ({1'b0, raw[32:1]} + 33'd1) : (33'd0 - {1'b0, raw[32:1]});
            val  = (kind == KSE) ? sv : raw;
            case (ph)
               EC_PROFILE: begin
                  prof_in = raw[7:0];
                  warn = !(is_high(raw[7:0]) || raw[7:0] == 8'd66 ||
                           raw[7:0] == 8'd77 || raw[7:0] == 8'd88);
               end
               EC_SPS_ID: nxt = is_high(prof) ? EC_CHROMA_FORMAT : EC_LOG2_FRAME_NUM;
               EC_CHROMA_FORMAT: begin
                  cf_in = (raw <= 33'd3) ? raw[1:0] : 2'd0;
                  nxt   = (raw == 33'd3) ? EC_SEP_PLANE : EC_DEPTH_LUMA;
               end
               EC_DEPTH_LUMA: begin
                  if (({1'b0, raw} + 34'd8) > {29'd0, mbd_ff}) pf_in[F_LUMA] = 1'b1;
               end
               EC_DEPTH_CHROMA: begin
                  if (pf[F_LUMA] || (({1'b0, raw} + 34'd8) > {29'd0, mbd_ff}))
                     err = ERR_DEPTH;
               end
               EC_SCALING_MATRIX: begin
                  ln_in = '0;
                  nxt   = (raw != '0) ? EC_LIST_PRESENT : EC_LOG2_FRAME_NUM;
               end
               EC_LIST_PRESENT: begin
                  idx = {4'd0, ln};
                  if (raw != '0) begin
                     sp_in = '0; ls_in = 8'd8; nxt = EC_SCALE_VALUE;
                  end else begin
                     ln_in = nl_num; nxt = nl_code;
                  end
               end
               EC_SCALE_VALUE: begin
                  ns   = ls + sv[7:0];
                  dflt = (pos == '0) && (ns == '0);
                  if (ns == '0) begin
                     code  = EC_SCALE_FILL;
                     idx   = {2'd0, pos};
                     val   = {25'd0, ls};
                     ln_in = nl_num;
                     nxt   = nl_code;
                  end else begin
                     idx   = size16 ? {4'd0, ZZ4[pos[3:0]]} : {2'd0, ZZ8[pos]};
                     val   = {25'd0, ns};
                     ls_in = ns;
                     if (pos_p1 >= (size16 ? 7'd16 : 7'd64)) begin
                        ln_in = nl_num; nxt = nl_code;
                     end else begin
                        sp_in = pos_p1[5:0]; nxt = EC_SCALE_VALUE;
                     end
                  end
               end
               EC_POC_TYPE: begin
                  nxt = (raw == 33'd0) ? EC_POC_LSB :
                        (raw == 33'd1) ? EC_DELTA_ZERO : EC_MAX_REF;
               end
               EC_POC_LSB: nxt = EC_MAX_REF;
               EC_POC_CYCLE: begin
                  if (raw > 33'(MAX_POC_CYCLE)) begin
                     err = ERR_COUNT;
                  end else if (raw == '0) begin
                     nxt = EC_MAX_REF;
                  end else begin
                     lc_in = '0; ll_in = raw[7:0] - 8'd1; nxt = EC_REF_OFFSET;
                  end
               end
               EC_REF_OFFSET: begin
                  idx = lc;
                  if (lc >= ll) begin
                     nxt = EC_MAX_REF;
                  end else begin
                     lc_in = lc + 8'd1; nxt = EC_REF_OFFSET;
                  end
               end
               EC_FRAME_MBS: nxt = (raw != '0) ? EC_DIRECT8X8 : EC_MB_ADAPTIVE;
               EC_CROP:      nxt = (raw != '0) ? EC_CROP_LEFT : EC_VUI;
               EC_VUI:       fin = (raw == '0);
               EC_ASPECT_PRESENT: nxt = (raw != '0) ? EC_ASPECT_IDC : EC_OVERSCAN;
               EC_ASPECT_IDC: nxt = (raw == 33'd255) ? EC_SAR_WIDTH : EC_OVERSCAN;
               EC_OVERSCAN: nxt = (raw != '0) ? EC_OVERSCAN_APPR : EC_VIDEO_SIGNAL;
               EC_VIDEO_SIGNAL: nxt = (raw != '0) ? EC_VIDEO_FORMAT : EC_CHROMA_LOC;
               EC_COLOUR_DESC: nxt = (raw != '0) ? EC_COLOUR_PRIM : EC_CHROMA_LOC;
               EC_CHROMA_LOC: nxt = (raw != '0) ? EC_LOC_TOP : EC_TIMING;
               EC_TIMING:     nxt = (raw != '0) ? EC_UNITS_IN_TICK : EC_NAL_HRD;
               EC_NAL_HRD: begin
                  if (raw != '0) pf_in[F_NAL] = 1'b1;
                  nxt = (raw != '0) ? EC_NAL_CPB_CNT : EC_VCL_HRD;
               end
               EC_NAL_CPB_CNT, EC_VCL_CPB_CNT: begin
                  if (raw > 33'(MAX_CPB_COUNT - 1)) begin
                     err = ERR_COUNT;
                  end else begin
                     lc_in = '0; ll_in = raw[7:0];
                  end
               end
               EC_NAL_BIT_RATE, EC_NAL_CPB_SIZE, EC_VCL_BIT_RATE, EC_VCL_CPB_SIZE:
                  idx = lc;
               EC_NAL_CBR, EC_VCL_CBR: begin
                  idx = lc;
                  if (lc < ll) begin
                     lc_in = lc + 8'd1; nxt = ph - 7'd2;
                  end
               end
               EC_VCL_HRD: begin
                  if (raw != '0) pf_in[F_VCL] = 1'b1;
                  nxt = (raw != '0) ? EC_VCL_CPB_CNT :
                        (pf[F_NAL] ? EC_LOW_DELAY : EC_PIC_STRUCT);
               end
               EC_RESTRICTION: fin = (raw == '0);
               EC_MAX_DEC_BUF: fin = 1'b1;
               default: ;
            endcase
            if (err != ERR_NONE) fin = 1'b1;

            rsp_push             = 1'b1;
            rsp_data.code        = code;
            rsp_data.index       = idx;
            rsp_data.value       = val;
            rsp_data.use_default = dflt;
            rsp_data.warning     = warn;
            rsp_data.error       = err;
            rsp_data.final_res   = fin;

            // advance to the next element
            if (fin || (nxt >= 7'(NCODES))) begin
               phase_in = PH_IDLE;
            end else begin
               nkind    = KIND_TAB[nxt];
               phase_in = nxt;
               lz_in    = '0;
               acc_in   = '0;
               rem_in   = (nkind <= 7'd32) ? nkind[5:0] : '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         lz_ff    <= '0;
         acc_ff   <= '0;
         rem_ff   <= '0;
         prof_ff  <= '0;
         cf_ff    <= 2'd1;
         lc_ff    <= '0;
         ll_ff    <= '0;
         ln_ff    <= '0;
         sp_ff    <= '0;
         ls_ff    <= 8'd8;
         pf_ff    <= '0;
         mbd_ff   <= 5'd16;
      end else begin
         phase_ff <= phase_in;
         lz_ff    <= lz_in;
         acc_ff   <= acc_in;
         rem_ff   <= rem_in;
         prof_ff  <= prof_in;
         cf_ff    <= cf_in;
         lc_ff    <= lc_in;
         ll_ff    <= ll_in;
         ln_ff    <= ln_in;
         sp_ff    <= sp_in;
         ls_ff    <= ls_in;
         pf_ff    <= pf_in;
         if (cfg_write) mbd_ff <= cfg_max_depth;
      end
   end

endmodule

@@ hw/rtl/shp_checker.sv @@
// Port-level checks for the SPS header parser, bound to the top level.
module shp_checker
   import shp_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [6:0]  rsp_element_code,
   input logic [7:0]  rsp_element_index,
   input logic [32:0] rsp_value,
   input logic        rsp_use_default,
   input logic        rsp_profile_warning,
   input logic [1:0]  rsp_error_code,
   input logic        rsp_final_res
);

   // an error beat always ends the set
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_error_code != ERR_NONE) |-> rsp_final_res)
      else $error("error beat without final flag");

   // default matrix request only at scan start of a scaling list
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_use_default |->
         (rsp_element_index == 8'd0) &&
         ((rsp_element_code == EC_SCALE_VALUE) || (rsp_element_code == EC_SCALE_FILL)))
      else $error("use_default on wrong beat");

   // warning only on the profile beat
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_profile_warning |-> (rsp_element_code == EC_PROFILE))
      else $error("profile warning on wrong beat");

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_element_code) &&
         $stable(rsp_value))
      else $error("stalled result changed");

   // nothing is offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind h264_sps_header_parser shp_checker u_shp_checker (.*);

@@ tb/h264_sps_header_parser_test.sv @@
// Self-checking testbench for the SPS header parser: bitstream stimulus and element prediction.
`timescale 1ns / 1ps

module h264_sps_header_parser_test;
   import shp_pkg::*;

   typedef struct {
      bit st;
      bit b;
   } bit_beat_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;
   always #2 clock = ~clock;

   // block ports
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_start_req = 1'b0;
   logic        req_bit_value = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [6:0]  rsp_element_code;
   logic [7:0]  rsp_element_index;
   logic signed [32:0] rsp_value;
   logic        rsp_use_default;
   logic        rsp_profile_warning;
   logic [1:0]  rsp_error_code;
   logic        rsp_final_res;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [4:0]  csr_max_bit_depth = 5'd16;

   h264_sps_header_parser u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_start_req(req_start_req), .req_bit_value(req_bit_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_element_code(rsp_element_code), .rsp_element_index(rsp_element_index),
      .rsp_value(rsp_value), .rsp_use_default(rsp_use_default),
      .rsp_profile_warning(rsp_profile_warning), .rsp_error_code(rsp_error_code),
      .rsp_final_res(rsp_final_res),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_max_bit_depth(csr_max_bit_depth)
   );

   // stimulus and expectation stores
   bit_beat_type pending_bits[$];
   rsp_type     expected_elems[$];
   bit          stream[$];
   int          bits_taken = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;
   bit          calm;

   // predictor state
   logic [6:0]  ph;
   logic [5:0]  lzeros;
   logic [32:0] acc;
   logic [5:0]  remaining;
   logic [7:0]  profile;
   logic [1:0]  chroma_fmt;
   logic [1:0]  poc_kind;
   logic [7:0]  loop_cnt;
   logic [7:0]  loop_lim;
   logic [3:0]  list_no;
   logic [5:0]  scan_pos;
   logic [7:0]  last_sc;
   logic [7:0]  next_sc;
   logic [2:0]  flags;
   logic [4:0]  depth_limit = 5'd16;

   // long stretch without idling on either side
   assign calm = (bits_taken >= 450) && (bits_taken < 650);

   function automatic void clear_parse();
      lzeros = 0; acc = 0; remaining = 0; profile = 0; chroma_fmt = 2'd1;
      poc_kind = 0; loop_cnt = 0; loop_lim = 0; list_no = 0; scan_pos = 0;
      last_sc = 8'd8; next_sc = 8'd8; flags = 0;
   endfunction

   function automatic void enter_elem(logic [6:0] p);
      ph = p;
      lzeros = 0;
      acc = 0;
      remaining = (KIND_TAB[p] <= 7'd32) ? KIND_TAB[p][5:0] : 6'd0;
   endfunction

   function automatic logic [6:0] advance_list();
      logic [3:0] lim;
      lim = (chroma_fmt == 2'd3) ? 4'd12 : 4'd8;
      list_no = list_no + 4'd1;
      return (list_no < lim) ? EC_LIST_PRESENT : EC_LOG2_FRAME_NUM;
   endfunction

   // one finished element: compute the result beat and the next element
   function automatic void close_element(logic [32:0] raw);
      logic [6:0]  c, code, nxt;
      logic [7:0]  idx;
      logic [32:0] sv, val;
      logic        dflt, warn, fin;
      logic [1:0]  err;
      int          size, pos, sj;
      rsp_type     r;
      c = ph; code = ph; nxt = ph + 7'd1; idx = 0;
      dflt = 0; warn = 0; fin = 0; err = ERR_NONE;
      sv = raw[0] ? ((raw + 33'd1) >> 1) : (33'd0 - (raw >> 1));
      val = (KIND_TAB[c] == KSE) ? sv : raw;
      case (c)
         EC_PROFILE: begin
            profile = raw[7:0];
            warn = !(profile inside {8'd66, 8'd77, 8'd88, 8'd100, 8'd110, 8'd122,
                                     8'd244, 8'd44});
         end
         EC_SPS_ID: nxt = (profile inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44}) ?
                          EC_CHROMA_FORMAT : EC_LOG2_FRAME_NUM;
         EC_CHROMA_FORMAT: begin
            chroma_fmt = (raw <= 33'd3) ? raw[1:0] : 2'd0;
            nxt = (raw == 33'd3) ? EC_SEP_PLANE : EC_DEPTH_LUMA;
         end
         EC_DEPTH_LUMA: if (({1'b0, raw} + 34'd8) > depth_limit) flags[F_LUMA] = 1'b1;
         EC_DEPTH_CHROMA:
            if (flags[F_LUMA] || ({1'b0, raw} + 34'd8) > depth_limit) err = ERR_DEPTH;
         EC_SCALING_MATRIX: begin
            list_no = 0;
            nxt = raw[0] ? EC_LIST_PRESENT : EC_LOG2_FRAME_NUM;
         end
         EC_LIST_PRESENT: begin
            idx = {4'd0, list_no};
            if (raw[0]) begin
               scan_pos = 0; last_sc = 8'd8; next_sc = 8'd8; nxt = EC_SCALE_VALUE;
            end else begin
               nxt = advance_list();
            end
         end
         EC_SCALE_VALUE: begin
            size = (list_no < 4'd6) ? 16 : 64;
            pos = scan_pos;
            sj = (size == 16) ? ZZ4[pos & 15] : ZZ8[pos];
            next_sc = last_sc + sv[7:0];
            dflt = (pos == 0) && (next_sc == 0);
            if (next_sc == 0) begin
               code = EC_SCALE_FILL; idx = 8'(pos); val = {25'd0, last_sc};
               nxt = advance_list();
            end else begin
               idx = 8'(sj); val = {25'd0, next_sc}; last_sc = next_sc;
               if (pos + 1 >= size) nxt = advance_list();
               else begin
                  scan_pos = 6'(pos + 1); nxt = EC_SCALE_VALUE;
               end
            end
         end
         EC_POC_TYPE: begin
            poc_kind = (raw > 33'd2) ? 2'd2 : raw[1:0];
            nxt = (raw == 0) ? EC_POC_LSB : (raw == 1) ? EC_DELTA_ZERO : EC_MAX_REF;
         end
         EC_POC_LSB: nxt = EC_MAX_REF;
         EC_POC_CYCLE: begin
            if (raw > MAX_POC_CYCLE) err = ERR_COUNT;
            else if (raw == 0) nxt = EC_MAX_REF;
            else begin
               loop_cnt = 0; loop_lim = raw[7:0] - 8'd1; nxt = EC_REF_OFFSET;
            end
         end
         EC_REF_OFFSET: begin
            idx = loop_cnt;
            if (loop_cnt >= loop_lim) nxt = EC_MAX_REF;
            else begin
               loop_cnt = loop_cnt + 8'd1; nxt = EC_REF_OFFSET;
            end
         end
         EC_FRAME_MBS: nxt = raw[0] ? EC_DIRECT8X8 : EC_MB_ADAPTIVE;
         EC_CROP: nxt = raw[0] ? EC_CROP_LEFT : EC_VUI;
         EC_VUI: if (!raw[0]) fin = 1;
         EC_ASPECT_PRESENT: nxt = raw[0] ? EC_ASPECT_IDC : EC_OVERSCAN;
         EC_ASPECT_IDC: nxt = (raw == 33'd255) ? EC_SAR_WIDTH : EC_OVERSCAN;
         EC_OVERSCAN: nxt = raw[0] ? EC_OVERSCAN_APPR : EC_VIDEO_SIGNAL;
         EC_VIDEO_SIGNAL: nxt = raw[0] ? EC_VIDEO_FORMAT : EC_CHROMA_LOC;
         EC_COLOUR_DESC: nxt = raw[0] ? EC_COLOUR_PRIM : EC_CHROMA_LOC;
         EC_CHROMA_LOC: nxt = raw[0] ? EC_LOC_TOP : EC_TIMING;
         EC_TIMING: nxt = raw[0] ? EC_UNITS_IN_TICK : EC_NAL_HRD;
         EC_NAL_HRD: begin
            if (raw[0]) flags[F_NAL] = 1'b1;
            nxt = raw[0] ? EC_NAL_CPB_CNT : EC_VCL_HRD;
         end
         EC_NAL_CPB_CNT, EC_VCL_CPB_CNT: begin
            if (raw > MAX_CPB_COUNT - 1) err = ERR_COUNT;
            else begin
               loop_cnt = 0; loop_lim = raw[7:0];
            end
         end
         EC_NAL_BIT_RATE, EC_NAL_CPB_SIZE, EC_VCL_BIT_RATE, EC_VCL_CPB_SIZE: idx = loop_cnt;
         EC_NAL_CBR, EC_VCL_CBR: begin
            idx = loop_cnt;
            if (loop_cnt < loop_lim) begin
               loop_cnt = loop_cnt + 8'd1; nxt = c - 7'd2;
            end
         end
         EC_VCL_HRD: begin
            if (raw[0]) flags[F_VCL] = 1'b1;
            nxt = raw[0] ? EC_VCL_CPB_CNT :
                  ((flags[F_NAL] || flags[F_VCL]) ? EC_LOW_DELAY : EC_PIC_STRUCT);
         end
         EC_RESTRICTION: if (!raw[0]) fin = 1;
         EC_MAX_DEC_BUF: fin = 1;
         default: ;
      endcase
      if (err != ERR_NONE) fin = 1;
      r.code = code; r.index = idx; r.value = val; r.use_default = dflt;
      r.warning = warn; r.error = err; r.final_res = fin;
      expected_elems.push_back(r);
      if (fin || nxt >= NCODES) ph = PH_IDLE;
      else enter_elem(nxt);
   endfunction

   // one accepted payload bit
   function automatic void parse_bit(bit st, bit b);
      rsp_type r;
      if (st) begin
         clear_parse();
         enter_elem(EC_PROFILE);
      end else if (ph >= NCODES) begin
         return;
      end
      if (KIND_TAB[ph] < KUE) begin
         acc = {acc[31:0], b};
         if (remaining > 0) remaining--;
         if (remaining == 0) close_element(acc);
      end else if (acc == 0) begin
         if (!b) begin
            lzeros = lzeros + 6'd1;
            if (lzeros >= MAX_LEADING_ZEROS) begin
               r.code = ph; r.index = 0; r.value = 0; r.use_default = 0;
               r.warning = 0; r.error = ERR_GOLOMB; r.final_res = 1;
               expected_elems.push_back(r);
               ph = PH_IDLE;
            end
         end else if (lzeros == 0) begin
            close_element(33'd0);
         end else begin
            acc = 33'd1;
            remaining = lzeros;
         end
      end else begin
         acc = {acc[31:0], b};
         if (remaining > 0) remaining--;
         if (remaining == 0) close_element(acc - 33'd1);
      end
   endfunction

   // bitstream writers
   function automatic void put_u(int n, longint unsigned v);
      for (int i = n - 1; i >= 0; i--) stream.push_back(v[i]);
   endfunction

   function automatic void put_ue(longint unsigned v);
      longint unsigned x;
      int nb;
      x = v + 1;
      nb = 0;
      while ((x >> nb) > 1) nb++;
      repeat (nb) stream.push_back(1'b0);
      put_u(nb + 1, x);
   endfunction

   function automatic void put_se(longint v);
      put_ue(v > 0 ? 2 * v - 1 : -2 * v);
   endfunction

   function automatic longint unsigned rnd_ue();
      int r;
      r = $urandom_range(99);
      if (r < 80) return $urandom_range(0, 10);
      if (r < 96) return $urandom_range(0, 65535);
      return {32'd0, $urandom};
   endfunction

   function automatic longint rnd_se();
      int r;
      r = $urandom_range(99);
      if (r < 85) return $signed($urandom_range(0, 40)) - 20;
      return $signed({1'b0, $urandom_range(0, 32'h7fff_ffff)}) * ($urandom_range(1) ? 1 : -1);
   endfunction

   function automatic void put_hrd();
      int cnt;
      cnt = ($urandom_range(9) == 0) ? $urandom_range(30, 33) : $urandom_range(0, 3);
      put_ue(cnt);
      if (cnt > MAX_CPB_COUNT - 1) return;
      put_u(4, $urandom_range(15)); put_u(4, $urandom_range(15));
      for (int i = 0; i <= cnt; i++) begin
         put_ue(rnd_ue()); put_ue(rnd_ue()); put_u(1, $urandom_range(1));
      end
      repeat (4) put_u(5, $urandom_range(31));
   endfunction

   // parameter set with random content, at times with out-of-range values
   function automatic void put_sps();
      int unsigned prof, cf, poc, n, nlists, size, last, nxt, dlt;
      bit nal, vcl;
      bit [7:0] plist[8] = '{66, 77, 88, 100, 110, 122, 244, 44};
      prof = ($urandom_range(7) == 0) ? $urandom_range(255) : plist[$urandom_range(7)];
      put_u(8, prof);
      repeat (4) put_u(1, $urandom_range(1));
      put_u(4, $urandom_range(15)); put_u(8, $urandom_range(255)); put_ue(rnd_ue());
      if (prof inside {100, 110, 122, 244, 44}) begin
         cf = ($urandom_range(5) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
         put_ue(cf);
         if (cf == 3) put_u(1, $urandom_range(1));
         put_ue($urandom_range(0, 9)); put_ue($urandom_range(0, 9));
         put_u(1, $urandom_range(1));
         if ($urandom_range(2) == 0) begin
            put_u(1, 1);
            nlists = (cf == 3) ? 12 : 8;
            for (int l = 0; l < nlists; l++) begin
               if ($urandom_range(2) == 0) begin
                  put_u(1, 0);
                  continue;
               end
               put_u(1, 1);
               size = (l < 6) ? 16 : 64;
               last = 8;
               for (int j = 0; j < size; j++) begin
                  if ($urandom_range(19) == 0) dlt = 256 - last;
                  else dlt = $urandom_range(1, 255);
                  // delta chosen in -128..127 with the same result mod 256
                  put_se(dlt >= 128 ? longint'(dlt) - 256 : longint'(dlt));
                  nxt = (last + dlt) & 255;
                  if (nxt == 0) break;
                  last = nxt;
               end
            end
         end else begin
            put_u(1, 0);
         end
      end
      put_ue(rnd_ue());
      poc = ($urandom_range(7) == 0) ? $urandom_range(3, 5) : $urandom_range(0, 2);
      put_ue(poc);
      if (poc == 0) put_ue(rnd_ue());
      else if (poc == 1) begin
         put_u(1, $urandom_range(1)); put_se(rnd_se()); put_se(rnd_se());
         n = ($urandom_range(9) == 0) ? $urandom_range(256, 257) : $urandom_range(0, 4);
         put_ue(n);
         if (n > MAX_POC_CYCLE) return;
         repeat (n) put_se(($urandom_range(9) == 0) ? rnd_se() : $urandom_range(0, 4));
      end
      put_ue(rnd_ue()); put_u(1, $urandom_range(1)); put_ue(rnd_ue()); put_ue(rnd_ue());
      if ($urandom_range(1)) put_u(1, 1);
      else begin
         put_u(1, 0); put_u(1, $urandom_range(1));
      end
      put_u(1, $urandom_range(1));
      if ($urandom_range(1)) begin
         put_u(1, 1); repeat (4) put_ue(rnd_ue());
      end else put_u(1, 0);
      if ($urandom_range(4) == 0) begin
         put_u(1, 0);
         return;
      end
      put_u(1, 1);
      if ($urandom_range(1)) begin
         put_u(1, 1);
         if ($urandom_range(1)) begin
            put_u(8, 255); put_u(16, $urandom_range(65535)); put_u(16, $urandom_range(65535));
         end else put_u(8, $urandom_range(254));
      end else put_u(1, 0);
      if ($urandom_range(1)) begin
         put_u(1, 1); put_u(1, $urandom_range(1));
      end else put_u(1, 0);
      if ($urandom_range(1)) begin
         put_u(1, 1); put_u(3, $urandom_range(7)); put_u(1, $urandom_range(1));
         if ($urandom_range(1)) begin
            put_u(1, 1); repeat (3) put_u(8, $urandom_range(255));
         end else put_u(1, 0);
      end else put_u(1, 0);
      if ($urandom_range(1)) begin
         put_u(1, 1); put_ue(rnd_ue()); put_ue(rnd_ue());
      end else put_u(1, 0);
      if ($urandom_range(1)) begin
         put_u(1, 1); put_u(32, $urandom); put_u(32, $urandom); put_u(1, $urandom_range(1));
      end else put_u(1, 0);
      nal = $urandom_range(1);
      put_u(1, nal);
      if (nal) put_hrd();
      vcl = $urandom_range(1);
      put_u(1, vcl);
      if (vcl) put_hrd();
      if (nal || vcl) put_u(1, $urandom_range(1));
      put_u(1, $urandom_range(1));
      if ($urandom_range(1)) begin
         put_u(1, 1); put_u(1, $urandom_range(1)); repeat (6) put_ue(rnd_ue());
      end else put_u(1, 0);
   endfunction

   // move the stream into the pending beats; the first bit carries start
   function automatic void queue_stream(bit with_start);
      bit_beat_type bt;
      foreach (stream[i]) begin
         bt.st = with_start && (i == 0);
         bt.b = stream[i];
         pending_bits.push_back(bt);
      end
      stream.delete();
   endfunction

   // noise: idle bits, broken sets, long zero runs
   function automatic void queue_noise();
      int r;
      r = $urandom_range(2);
      if (r == 0) begin
         repeat ($urandom_range(1, 6)) stream.push_back($urandom_range(1));
         queue_stream(1'b0);
      end else if (r == 1) begin
         put_u(24, $urandom); put_u(8, $urandom_range(255));
         repeat ($urandom_range(28, 34)) stream.push_back(1'b0);
         queue_stream(1'b1);
      end else begin
         repeat ($urandom_range(1, 40)) stream.push_back($urandom_range(1));
         queue_stream(1'b1);
      end
   endfunction

   task automatic wait_quiet();
      while (pending_bits.size() > 0 || req_valid || expected_elems.size() > 0)
         @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_depth(logic [4:0] v);
      csr_valid <= 1'b1;
      csr_max_bit_depth <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      depth_limit = v;
      csr_valid <= 1'b0;
   endtask

   // sequence of phases with register changes in between
   initial begin
      logic [4:0] depths[5];
      int goal;
      ph = PH_IDLE;
      clear_parse();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      depths = '{5'd16, 5'd8, 5'(9 + $urandom_range(6)), 5'd16, 5'd12};
      // directed: bits while idle, then a set cut short by a restart
      write_depth(depths[0]);
      stream = '{1, 0, 1};
      queue_stream(1'b0);
      put_u(8, 100); put_u(8, 8'hf0); put_u(4, 0); put_u(1, 1);
      queue_stream(1'b1);
      goal = 0;
      for (int p = 0; p < 5; p++) begin
         if (p > 0) begin
            wait_quiet();
            write_depth(depths[p]);
         end
         goal += 230;
         while (bits_taken + pending_bits.size() < goal) begin
            if ($urandom_range(4) == 0) queue_noise();
            else begin
               put_sps();
               repeat ($urandom_range(0, 4)) stream.push_back($urandom_range(1));
               queue_stream(1'b1);
            end
            // cut the tail so each phase sends its share of bits
            while (bits_taken + pending_bits.size() > goal)
               pending_bits.delete(pending_bits.size() - 1);
            while (pending_bits.size() > 40) @(posedge clock);
         end
      end
      wait_quiet();
      if (fail_count == 0) $display("h264_sps_header_parser regression: pass");
      else $display("h264_sps_header_parser regression: fail");
      $finish;
   end

   // bit driver: predict on every accepted beat, then present the next one
   always @(posedge clock) begin
      bit_beat_type bt;
      if (reset) begin
         req_valid <= 1'b0;
         req_start_req <= 1'b0;
         req_bit_value <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_bit(req_start_req, req_bit_value);
            bits_taken++;
         end
         if (!req_valid || !req_stall) begin
            if (pending_bits.size() > 0 && (calm || $urandom_range(99) >= 23)) begin
               bt = pending_bits.pop_front();
               req_valid <= 1'b1;
               req_start_req <= bt.st;
               req_bit_value <= bt.b;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(string name, longint unsigned exp_v, longint unsigned got_v);
      if (exp_v !== got_v) begin
         $error("%s mismatch: expected %0h, got %0h", name, exp_v, got_v);
         fail_count++;
      end
   endtask

   // element monitor
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_elems.size() == 0) begin
               $error("element beat with nothing expected: code %0d", rsp_element_code);
               fail_count++;
            end else begin
               e = expected_elems.pop_front();
               check_field("element_code", e.code, rsp_element_code);
               check_field("element_index", e.index, rsp_element_index);
               check_field("value", e.value, rsp_value[32:0]);
               check_field("use_default", e.use_default, rsp_use_default);
               check_field("profile_warning", e.warning, rsp_profile_warning);
               check_field("error_code", e.error, rsp_error_code);
               check_field("final_res", e.final_res, rsp_final_res);
            end
         end
         rsp_stall <= !calm && ($urandom_range(99) < 23);
      end
   end

   // watchdog on cycles without any accepted beat
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("h264_sps_header_parser regression: fail");
         $finish;
      end
   end

endmodule
